>>> sv/csort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_pkg: shared types and constants of the stable counting sorter
// Request and result structs, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package csort_pkg;

    localparam int KEY_W = 7;
    localparam int TAG_W = 16;

    localparam int DEF_MAX_RECORDS = 64;
    localparam int DEF_KEY_RANGE   = 128;
    localparam int DEF_TAG_BITS    = 16;

    localparam logic [KEY_W-1:0] MAX_KEY_RESET = 7'd100;

    typedef struct packed {
        logic [KEY_W-1:0] item_key;
        logic [TAG_W-1:0] item_tag;
        logic             batch_last;
    } csort_in_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             key_clamped;
        logic             batch_overflow;
        logic             out_last;
    } csort_out_t;

endpackage

>>> sv/csort_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_ram: simple dual-port memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csort_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/csort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csort_ctrl: sort sequencer with shared count adder
// Loads records, then clears, counts, prefix-sums, scatters and emits.
// ----------------------------------------------------------------------------
module csort_ctrl #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_RANGE   = 128,
    parameter int TAG_BITS    = 16,
    parameter int RW          = 24,
    parameter int AW          = 6,
    parameter int KIDX        = 7,
    parameter int CW          = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  csort_pkg::csort_in_t            item,
    input  logic [csort_pkg::KEY_W-1:0]     max_key,
    output logic                            result_valid,
    output csort_pkg::csort_out_t           result,
    // record store
    output logic                            st_we,
    output logic [AW-1:0]                   st_waddr,
    output logic [RW-1:0]                   st_wdata,
    output logic [AW-1:0]                   st_raddr,
    input  logic [RW-1:0]                   st_rdata,
    // key counts
    output logic                            cn_we,
    output logic [KIDX-1:0]                 cn_waddr,
    output logic [CW-1:0]                   cn_wdata,
    output logic [KIDX-1:0]                 cn_raddr,
    input  logic [CW-1:0]                   cn_rdata,
    // sorted buffer
    output logic                            so_we,
    output logic [AW-1:0]                   so_waddr,
    output logic [RW-1:0]                   so_wdata,
    output logic [AW-1:0]                   so_raddr,
    input  logic [RW-1:0]                   so_rdata
);

    import csort_pkg::*;

    localparam int TB = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int HW = $clog2(MAX_RECORDS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_H_RS, S_H_RC, S_H_WR, S_P_RD, S_P_WR,
        S_S_RS, S_S_RC, S_S_WR, S_EMIT, S_E_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [HW-1:0]   held_reg, held_next;
    logic [HW-1:0]   n_reg, n_next;
    logic [HW-1:0]   idx_reg, idx_next;
    logic [KIDX-1:0] caddr_reg, caddr_next;
    logic [CW-1:0]   acc_reg, acc_next;
    logic [RW-1:0]   rec_reg, rec_next;
    logic            ovf_reg, ovf_next;
    logic            vld_reg, vld_next;
    logic            last_reg, last_next;

    logic [KEY_W-1:0] lim;
    logic [KEY_W-1:0] key_in;
    logic             clamp_in;
    logic [HW-1:0]    scat_idx;
    logic [HW-1:0]    idx_inc;
    logic [CW-1:0]    alu_b;
    logic [CW-1:0]    alu_sum;
    logic             room;

    // effective key limit: max_key, capped by the count table depth
    always_comb
    begin
        if (32'(max_key) > KEY_RANGE - 1)
        begin
            lim = KEY_W'(KEY_RANGE - 1);
        end
        else
        begin
            lim = max_key;
        end
    end

    assign clamp_in = (item.item_key > lim);
    assign key_in   = clamp_in ? lim : item.item_key;
    assign room     = (held_reg < HW'(MAX_RECORDS));
    assign scat_idx = idx_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;

    // shared count adder: +1 on count, +running sum on prefix, -1 on scatter
    assign alu_sum = cn_rdata + alu_b;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = vld_reg;

    always_comb
    begin
        result.sorted_key     = so_rdata[TB+KEY_W-1:TB];
        result.sorted_tag     = TAG_W'(so_rdata[TB-1:0]);
        result.key_clamped    = so_rdata[RW-1];
        result.batch_overflow = ovf_reg;
        result.out_last       = last_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        caddr_next = caddr_reg;
        acc_next   = acc_reg;
        rec_next   = rec_reg;
        ovf_next   = ovf_reg;
        vld_next   = 1'b0;
        last_next  = last_reg;

        st_we    = 1'b0;
        st_waddr = held_reg[AW-1:0];
        st_wdata = {clamp_in, key_in, TB'(item.item_tag)};
        st_raddr = idx_reg[AW-1:0];
        cn_we    = 1'b0;
        cn_waddr = caddr_reg;
        cn_wdata = alu_sum;
        cn_raddr = caddr_reg;
        so_we    = 1'b0;
        so_waddr = alu_sum[AW-1:0];
        so_wdata = rec_reg;
        so_raddr = idx_reg[AW-1:0];
        alu_b    = acc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        st_we     = 1'b1;
                        held_next = held_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.batch_last)
                    begin
                        n_next     = room ? held_reg + 1'b1 : held_reg;
                        caddr_next = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cn_we    = 1'b1;
                cn_wdata = '0;
                if (caddr_reg == KIDX'(KEY_RANGE - 1))
                begin
                    idx_next   = '0;
                    state_next = S_H_RS;
                end
                else
                begin
                    caddr_next = caddr_reg + 1'b1;
                end
            end
            S_H_RS:
            begin
                state_next = S_H_RC;
            end
            S_H_RC:
            begin
                cn_raddr   = KIDX'(st_rdata[TB+KEY_W-1:TB]);
                rec_next   = st_rdata;
                state_next = S_H_WR;
            end
            S_H_WR:
            begin
                alu_b    = CW'(1);
                cn_we    = 1'b1;
                cn_waddr = KIDX'(rec_reg[TB+KEY_W-1:TB]);
                idx_next = idx_inc;
                if (idx_inc == n_reg)
                begin
                    caddr_next = '0;
                    acc_next   = '0;
                    state_next = S_P_RD;
                end
                else
                begin
                    state_next = S_H_RS;
                end
            end
            S_P_RD:
            begin
                state_next = S_P_WR;
            end
            S_P_WR:
            begin
                cn_we    = 1'b1;
                acc_next = alu_sum;
                if (caddr_reg == KIDX'(lim))
                begin
                    idx_next   = n_reg;
                    state_next = S_S_RS;
                end
                else
                begin
                    caddr_next = caddr_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end
            S_S_RS:
            begin
                st_raddr   = scat_idx[AW-1:0];
                state_next = S_S_RC;
            end
            S_S_RC:
            begin
                cn_raddr   = KIDX'(st_rdata[TB+KEY_W-1:TB]);
                rec_next   = st_rdata;
                state_next = S_S_WR;
            end
            S_S_WR:
            begin
                // position is count - 1; the count drops to the same value
                alu_b    = '1;
                cn_we    = 1'b1;
                cn_waddr = KIDX'(rec_reg[TB+KEY_W-1:TB]);
                so_we    = (alu_sum < CW'(MAX_RECORDS));
                idx_next = scat_idx;
                if (idx_reg == HW'(1))
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_S_RS;
                end
            end
            S_EMIT:
            begin
                vld_next  = 1'b1;
                last_next = (idx_inc == n_reg);
                idx_next  = idx_inc;
                if (idx_inc == n_reg)
                begin
                    state_next = S_E_DONE;
                end
            end
            S_E_DONE:
            begin
                held_next  = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            caddr_reg <= '0;
            acc_reg   <= '0;
            rec_reg   <= '0;
            ovf_reg   <= 1'b0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            caddr_reg <= caddr_next;
            acc_reg   <= acc_next;
            rec_reg   <= rec_next;
            ovf_reg   <= ovf_next;
            vld_reg   <= vld_next;
            last_reg  <= last_next;
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(MAX_RECORDS))
        else $error("record count above capacity");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> busy)
        else $error("result strobe while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && last_reg) |=> !vld_reg)
        else $error("result after final result of batch");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.batch_last) |=> (state_reg == S_CLEAR))
        else $error("final request did not start the sort");

endmodule

>>> sv/stable_counting_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_counting_sort: batch stable counting sorter
// Loads keyed records, sorts each batch by key with a counting sort, and
// emits the records in ascending key order, equal keys in arrival order.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------
//  request   start / busy           item   (key, tag, batch_last)
//  result    result_valid strobe    result (key, tag, clamp, ovf, last)
//  config    cfg_we                 cfg_data (max_key)
//
// A request is taken on a clock edge with start high and busy low.
// Requests without batch_last leave busy low, so another can follow.
// A request with batch_last starts the sort; busy stays high through the
//   count clear, histogram, prefix, scatter and emit passes, paced by the
//   registered reads of the record and count memories.
// Results come out one per cycle during the emit pass; the receiver
// cannot stall them. Reset clears the control state; memories need none.
// ----------------------------------------------------------------------------
module stable_counting_sort #(
    parameter int MAX_RECORDS = csort_pkg::DEF_MAX_RECORDS,
    parameter int KEY_RANGE   = csort_pkg::DEF_KEY_RANGE,
    parameter int TAG_BITS    = csort_pkg::DEF_TAG_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  csort_pkg::csort_in_t        item,
    input  logic                        cfg_we,
    input  logic [csort_pkg::KEY_W-1:0] cfg_data,
    output logic                        result_valid,
    output csort_pkg::csort_out_t       result
);

    import csort_pkg::*;

    // stored tag keeps only the low TAG_BITS bits of the field
    localparam int TB   = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int RW   = 1 + KEY_W + TB;
    localparam int AW   = $clog2(MAX_RECORDS);
    localparam int KIDX = $clog2(KEY_RANGE);
    // one spare bit so a count that wraps below zero never looks like a slot
    localparam int CW   = $clog2(MAX_RECORDS + 1) + 1;

    logic [KEY_W-1:0] max_key_reg;

    logic            st_we, cn_we, so_we;
    logic [AW-1:0]   st_waddr, st_raddr, so_waddr, so_raddr;
    logic [RW-1:0]   st_wdata, st_rdata, so_wdata, so_rdata;
    logic [KIDX-1:0] cn_waddr, cn_raddr;
    logic [CW-1:0]   cn_wdata, cn_rdata;

    // hold the key limit; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_key_reg <= MAX_KEY_RESET;
        end
        else if (cfg_we)
        begin
            max_key_reg <= cfg_data;
        end
    end

    csort_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .KEY_RANGE   (KEY_RANGE),
        .TAG_BITS    (TAG_BITS),
        .RW          (RW),
        .AW          (AW),
        .KIDX        (KIDX),
        .CW          (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .max_key      (max_key_reg),
        .result_valid (result_valid),
        .result       (result),
        .st_we        (st_we),
        .st_waddr     (st_waddr),
        .st_wdata     (st_wdata),
        .st_raddr     (st_raddr),
        .st_rdata     (st_rdata),
        .cn_we        (cn_we),
        .cn_waddr     (cn_waddr),
        .cn_wdata     (cn_wdata),
        .cn_raddr     (cn_raddr),
        .cn_rdata     (cn_rdata),
        .so_we        (so_we),
        .so_waddr     (so_waddr),
        .so_wdata     (so_wdata),
        .so_raddr     (so_raddr),
        .so_rdata     (so_rdata)
    );

    // records in arrival order
    csort_ram #(.W(RW), .D(MAX_RECORDS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // key histogram, then running end positions; cleared at each sort start
    csort_ram #(.W(CW), .D(KEY_RANGE)) u_counts (
        .clk   (clk),
        .we    (cn_we),
        .waddr (cn_waddr),
        .wdata (cn_wdata),
        .raddr (cn_raddr),
        .rdata (cn_rdata)
    );

    // records in sorted order, drained by the emit pass
    csort_ram #(.W(RW), .D(MAX_RECORDS)) u_sorted (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

endmodule
